// ----- hdl/can_bit_timing_solver_macros.svh -----
// ----------------------------------------------------------------------------
// CAN bit timing solver assertion macros
// Shorthand for clocked assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef CAN_BIT_TIMING_SOLVER_MACROS_SVH
`define CAN_BIT_TIMING_SOLVER_MACROS_SVH

// same-cycle implication
`define CBTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbts assertion failed");

// next-cycle implication
`define CBTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbts assertion failed");

`endif

// ----- hdl/cbts_pkg.sv -----
// ----------------------------------------------------------------------------
// CAN bit timing solver package
// Shared constants, word types, controller/datapath interface and
// segment helper functions.
// ----------------------------------------------------------------------------
package cbts_pkg;

  localparam int MAX_QUANTA    = 16;
  localparam int MIN_QUANTA    = 8;
  localparam int PRESCALER_MAX = 1024;

  localparam int QW  = $clog2(MAX_QUANTA + 1);
  localparam int DW  = 32 + QW;
  localparam int CNTW = 5;

  typedef struct packed {
    logic [31:0] clock_hz;
    logic [31:0] rate_bps;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  quanta_per_bit;
    logic [9:0]  prescaler_minus_one;
    logic [3:0]  seg1_minus_one;
    logic [2:0]  seg2_minus_one;
    logic [22:0] timing_word;
  } out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic next_q;
    logic emit;
    logic emit_found;
  } cmd_t;

  typedef struct packed {
    logic zero_in;
    logic div_last;
    logic fit;
    logic q_last;
  } status_t;

  // floor(4*q/5) as a reciprocal multiply, exact while 4*q stays below 1024
  function automatic int four_fifths(input logic [QW-1:0] q);
    begin
      four_fifths = (int'(q) * 4 * 205) >> 10;
    end
  endfunction

  function automatic logic seg_ok(input logic [QW-1:0] q);
    int four5;
    int s1;
    int s2;
    begin
      four5 = four_fifths(q);
      s1 = four5 - 1;
      s2 = int'(q) - 1 - s1;
      seg_ok = (four5 >= 2) && (int'(q) >= s1 + 2) && (s1 >= 1) && (s1 <= 16) &&
               (s2 >= 1) && (s2 <= 8);
    end
  endfunction

  function automatic logic [3:0] seg1_m1(input logic [QW-1:0] q);
    int four5;
    begin
      four5 = four_fifths(q);
      seg1_m1 = 4'(four5 - 2);
    end
  endfunction

  function automatic logic [2:0] seg2_m1(input logic [QW-1:0] q);
    int four5;
    begin
      four5 = four_fifths(q);
      seg2_m1 = 3'(int'(q) - four5 - 1);
    end
  endfunction

endpackage

// ----- hdl/cbts_dpath.sv -----
// ----------------------------------------------------------------------------
// CAN bit timing solver datapath
// Trial quanta count, denominator product, bit-serial restoring divider
// and result register.
// ----------------------------------------------------------------------------
module cbts_dpath
  import cbts_pkg::*;
(
  input  logic    clk,
  input  in_t     in_data,
  input  cmd_t    cmd,
  output status_t status,
  output out_t    out_data
);

  localparam logic [31:0] PRESC_MAX_W = 32'(PRESCALER_MAX);

  logic [31:0]     clk_r;
  logic [31:0]     rate_r;
  logic [QW-1:0]   q_r;
  logic [DW-1:0]   denom_r;
  logic [DW-1:0]   rem_r;
  logic [31:0]     quot_r;
  logic [CNTW-1:0] cnt_r;
  out_t            out_r;

  logic [DW:0]     rem_shift;
  logic            ge;
  logic [DW:0]     rem_sub;
  logic [9:0]      pm1;
  logic [3:0]      s1m1;
  logic [2:0]      s2m1;

  assign rem_shift = {rem_r, clk_r[cnt_r]};
  assign ge        = rem_shift >= {1'b0, denom_r};
  assign rem_sub   = rem_shift - {1'b0, denom_r};

  assign pm1  = 10'(quot_r - 32'd1);
  assign s1m1 = seg1_m1(q_r);
  assign s2m1 = seg2_m1(q_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      clk_r  <= in_data.clock_hz;
      rate_r <= in_data.rate_bps;
      q_r    <= QW'(MAX_QUANTA);
    end
    if (cmd.prep) begin
      denom_r <= DW'(rate_r) * DW'(q_r);
      rem_r   <= '0;
      quot_r  <= '0;
      cnt_r   <= '1;
    end
    if (cmd.step) begin
      rem_r  <= ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
      quot_r <= {quot_r[30:0], ge};
      cnt_r  <= cnt_r - 1'b1;
    end
    if (cmd.next_q) begin
      q_r <= q_r - 1'b1;
    end
    if (cmd.emit) begin
      if (cmd.emit_found) begin
        out_r.found               <= 1'b1;
        out_r.quanta_per_bit      <= 5'(q_r);
        out_r.prescaler_minus_one <= pm1;
        out_r.seg1_minus_one      <= s1m1;
        out_r.seg2_minus_one      <= s2m1;
        out_r.timing_word         <= {s2m1, s1m1, 6'd0, pm1};
      end else begin
        out_r <= '0;
      end
    end
  end

  assign status.zero_in  = (clk_r == '0) || (rate_r == '0);
  assign status.div_last = (cnt_r == '0);
  assign status.fit      = (rem_r == '0) && (quot_r != '0) && (quot_r <= PRESC_MAX_W) &&
                           seg_ok(q_r);
  assign status.q_last   = (q_r == QW'(MIN_QUANTA));

  assign out_data = out_r;

endmodule

// ----- hdl/cbts_ctrl.sv -----
// ----------------------------------------------------------------------------
// CAN bit timing solver controller
// Sequences trial counts through product, division and fit check.
// ----------------------------------------------------------------------------
module cbts_ctrl
  import cbts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_CHECK
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (status.zero_in) begin
          cmd.emit  = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.fit || status.q_last) begin
          cmd.emit       = 1'b1;
          cmd.emit_found = status.fit;
          valid_nxt      = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.next_q = 1'b1;
          state_nxt  = S_PREP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

// ----- hdl/can_bit_timing_solver.sv -----
// ----------------------------------------------------------------------------
// CAN bit timing solver
// Finds an exact prescaler and segment split for a clock and bit rate.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data (clock_hz, rate_bps) and raise start while busy is low;
//   the word is taken at that clock edge and busy rises.
//   Counts of 16 down to 8 quanta per bit are tried in turn until one fits.
//   Each trial forms rate times quanta, then runs a bit-serial restoring
//   divider over the clock_hz bits, top bit first, and checks the fit.
//   The result word appears on out_data with out_valid high for exactly one
//   cycle, after the fit check of the last trial run (1 to 9 trials). A zero
//   clock or bit rate is reported not found with no trial run. The shared
//   divider sets the rate: one word at a time, a new start may be given in
//   the strobe cycle.
//   The receiver cannot stall; out_data holds until the next result.
//   Synchronous reset (rst_n low) returns to idle with no strobe pending.
// ----------------------------------------------------------------------------
module can_bit_timing_solver
  import cbts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  cmd_t    cmd;
  status_t status;

  cbts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cbts_dpath u_dpath (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ----- hdl/cbts_checker.sv -----
// ----------------------------------------------------------------------------
// CAN bit timing solver checker
// Port-level checks on the start/busy handshake, the strobe and result word.
// ----------------------------------------------------------------------------
`include "can_bit_timing_solver_macros.svh"

module cbts_checker
  import cbts_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);

  logic miss_clear;
  logic hit_range;

  assign miss_clear = (out_data.timing_word == '0) && (out_data.quanta_per_bit == '0);
  assign hit_range  = (out_data.quanta_per_bit >= 5'(MIN_QUANTA)) &&
                      (out_data.quanta_per_bit <= 5'(MAX_QUANTA));

  `CBTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CBTS_ASSERT_NOW(a_strobe_after_busy, out_valid, $past(busy) && !busy)
  `CBTS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `CBTS_ASSERT_NOW(a_miss_zero, out_valid && !out_data.found, miss_clear)
  `CBTS_ASSERT_NOW(a_hit_range, out_valid && out_data.found, hit_range)

endmodule

bind can_bit_timing_solver cbts_checker u_cbts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
